>>> sv/swl_pkg.sv
// ----------------------------------------------------------------------------
// swl_pkg
// Shared types and constants of the session stopwatch: command codes, status
// flag masks, register map and the control bundle from the register block.
// ----------------------------------------------------------------------------
package swl_pkg;

   // request payload widths
   localparam int OPCODE_WIDTH = 6;
   localparam int DELTA_WIDTH  = 32;
   localparam int FLAGS_WIDTH  = 8;
   localparam int TIME_WIDTH   = 32;

   // register port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_LSB  = 2;

   // register indexes
   typedef enum logic [0:0] {
      REG_LOCK_AT_RESET = 1'b0
   } reg_index_type;

   // command codes; all codes from 7 up are no-ops
   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_START       = 6'd0,
      OP_TICK        = 6'd1,
      OP_STOP        = 6'd2,
      OP_ARM_SPLIT   = 6'd3,
      OP_DISARM_SPLIT = 6'd4,
      OP_ARM_LAP     = 6'd5,
      OP_DISARM_LAP  = 6'd6
   } op_type;

   // status flag masks
   localparam logic [FLAGS_WIDTH-1:0] FLAG_STOPPED = 8'h09;
   localparam logic [FLAGS_WIDTH-1:0] FLAG_RUNNING = 8'h02;
   localparam logic [FLAGS_WIDTH-1:0] FLAG_SPLIT   = 8'h10;
   localparam logic [FLAGS_WIDTH-1:0] FLAG_LAP0    = 8'h20;
   localparam logic [FLAGS_WIDTH-1:0] FLAG_LOCK    = 8'h80;

   // register block to datapath
   typedef struct packed {
      logic lock_wr;
      logic lock_value;
   } csr_ctrl_type;

   // armed bit of lap k; bits shifted past the flag byte are lost
   function automatic logic [FLAGS_WIDTH-1:0] lap_flag(input logic [1:0] k);
      logic [FLAGS_WIDTH+2:0] w;
      w = (FLAGS_WIDTH+3)'(FLAG_LAP0) << k;
      return w[FLAGS_WIDTH-1:0];
   endfunction

endpackage

>>> sv/swl_req_if.sv
// ----------------------------------------------------------------------------
// swl_req_if
// Command request channel: valid/ready handshake with one command payload.
// ----------------------------------------------------------------------------
interface swl_req_if
   import swl_pkg::*;
   ();

   logic                           valid;
   logic                           ready;
   logic [OPCODE_WIDTH-1:0]        opcode;
   logic                           lap_select;
   logic signed [DELTA_WIDTH-1:0]  delta;

   modport source (output valid, output opcode, output lap_select, output delta,
                   input ready);
   modport sink (input valid, input opcode, input lap_select, input delta,
                 output ready);

endinterface

>>> sv/swl_rsp_if.sv
// ----------------------------------------------------------------------------
// swl_rsp_if
// Result channel: valid/ready handshake carrying flags and all counters.
// ----------------------------------------------------------------------------
interface swl_rsp_if
   import swl_pkg::*;
   ();

   logic                          valid;
   logic                          ready;
   logic [FLAGS_WIDTH-1:0]        status_flags;
   logic signed [TIME_WIDTH-1:0]  run_time;
   logic signed [TIME_WIDTH-1:0]  total_time;
   logic signed [TIME_WIDTH-1:0]  split_time;
   logic signed [TIME_WIDTH-1:0]  lap_zero_time;
   logic signed [TIME_WIDTH-1:0]  lap_one_time;
   logic                          start_refused;

   modport source (output valid, output status_flags, output run_time,
                   output total_time, output split_time, output lap_zero_time,
                   output lap_one_time, output start_refused, input ready);
   modport sink (input valid, input status_flags, input run_time,
                 input total_time, input split_time, input lap_zero_time,
                 input lap_one_time, input start_refused, output ready);

endinterface

>>> sv/swl_csr.sv
// ----------------------------------------------------------------------------
// swl_csr
// APB register block: holds lock_at_reset and reports each write of it so the
// lock flag can be reloaded at once.
// ----------------------------------------------------------------------------
module swl_csr
   import swl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output csr_ctrl_type              csr_ctrl
);

   logic lock_at_reset_ff;
   logic lock_at_reset_in;
   logic hit;
   logic wr_en;

   // address decode
   assign hit   = (csr_paddr[CSR_INDEX_LSB] == REG_LOCK_AT_RESET);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && hit;

   assign lock_at_reset_in = wr_en ? csr_pwdata[0] : lock_at_reset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_at_reset_ff <= 1'b0;
      end else begin
         lock_at_reset_ff <= lock_at_reset_in;
      end
   end

   // read data, zero beyond the map
   assign csr_prdata = hit ? CSR_DATA_WIDTH'(lock_at_reset_ff) : '0;
   assign csr_pready = 1'b1;

   assign csr_ctrl.lock_wr    = wr_en;
   assign csr_ctrl.lock_value = csr_pwdata[0];

endmodule

>>> sv/swl_next.sv
// ----------------------------------------------------------------------------
// swl_next
// Command decode and counter update: computes the flags and counters after
// one command from the current state.
// ----------------------------------------------------------------------------
module swl_next
   import swl_pkg::*;
#(
   parameter int LAP_COUNT   = 2,
   parameter int COUNT_WIDTH = 32
) (
   input  logic [OPCODE_WIDTH-1:0]                  opcode,
   input  logic                                     lap_select,
   input  logic signed [DELTA_WIDTH-1:0]            delta,
   input  logic [FLAGS_WIDTH-1:0]                   flags_cur,
   input  logic [COUNT_WIDTH-1:0]                   run_cur,
   input  logic [COUNT_WIDTH-1:0]                   total_cur,
   input  logic [COUNT_WIDTH-1:0]                   split_cur,
   input  logic [LAP_COUNT-1:0][COUNT_WIDTH-1:0]    laps_cur,
   output logic [FLAGS_WIDTH-1:0]                   flags_nx,
   output logic [COUNT_WIDTH-1:0]                   run_nx,
   output logic [COUNT_WIDTH-1:0]                   total_nx,
   output logic [COUNT_WIDTH-1:0]                   split_nx,
   output logic [LAP_COUNT-1:0][COUNT_WIDTH-1:0]    laps_nx,
   output logic                                     refused
);

   logic [63:0]            delta_ext;
   logic [COUNT_WIDTH-1:0] step;

   // sign-extend, then wrap to the counter width
   assign delta_ext = 64'(delta);
   assign step      = delta_ext[COUNT_WIDTH-1:0];

   always_comb begin
      flags_nx = flags_cur;
      run_nx   = run_cur;
      total_nx = total_cur;
      split_nx = split_cur;
      laps_nx  = laps_cur;
      refused  = 1'b0;
      unique case (opcode)
         OP_START: begin
            if ((flags_cur & FLAG_LOCK) != '0) begin
               refused = 1'b1;
            end else begin
               run_nx   = '0;
               flags_nx = (flags_cur & ~FLAG_STOPPED) | FLAG_RUNNING;
            end
         end
         OP_TICK, OP_STOP: begin
            run_nx   = run_cur + step;
            total_nx = total_cur + step;
            if (opcode == OP_TICK && (flags_cur & FLAG_SPLIT) != '0) begin
               split_nx = split_cur + step;
            end
            // armed laps advance on the old flags
            for (int k = 0; k < LAP_COUNT; k++) begin
               if ((flags_cur & lap_flag(2'(k))) != '0) begin
                  laps_nx[k] = laps_cur[k] + step;
               end
            end
            if (opcode == OP_STOP) begin
               flags_nx = (flags_cur | FLAG_STOPPED) &
                          ~(FLAG_RUNNING | FLAG_SPLIT | FLAG_LOCK);
            end
         end
         OP_ARM_SPLIT: begin
            split_nx = '0;
            flags_nx = flags_cur | FLAG_SPLIT;
         end
         OP_DISARM_SPLIT: begin
            flags_nx = flags_cur & ~FLAG_SPLIT;
         end
         OP_ARM_LAP: begin
            // a select past the last lap matches nothing
            for (int k = 0; k < LAP_COUNT; k++) begin
               if (k == int'(lap_select)) begin
                  laps_nx[k] = '0;
                  flags_nx   = flags_cur | lap_flag(2'(k));
               end
            end
         end
         OP_DISARM_LAP: begin
            for (int k = 0; k < LAP_COUNT; k++) begin
               if (k == int'(lap_select)) begin
                  flags_nx = flags_cur & ~lap_flag(2'(k));
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/session_stopwatch_with_laps.sv
// ----------------------------------------------------------------------------
// session_stopwatch_with_laps
// Stopwatch with run, total, split and lap counters driven by commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per request (opcode, lap_select, delta);
//   rsp_chan returns one result per command: the flag byte, every counter
//   after the command, and start_refused for a start blocked by the lock.
//   The csr_ APB port holds lock_at_reset at address 0; a write also loads
//   the lock flag at once. Write it only while no command is in flight.
// Timing:
//   The state update and the result register load happen at the edge that
//   accepts the request, so a result is valid in the next cycle. While the
//   receiver keeps up, one request is taken every cycle; the single result
//   register sets the pace. req_chan.ready is high while the result register
//   is empty or its result is being taken, so a stalled receiver holds one
//   result and then stalls the sender with no loss.
// Reset:
//   Synchronous; clears all counters, the flag byte, lock_at_reset and the
//   result valid.
// ----------------------------------------------------------------------------
module session_stopwatch_with_laps
   import swl_pkg::*;
#(
   parameter int LAP_COUNT   = 2,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   swl_req_if.sink                   req_chan,
   swl_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // wrap or zero-extend a counter to the result width
   function automatic logic [TIME_WIDTH-1:0] fit_time(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[TIME_WIDTH-1:0];
   endfunction

   csr_ctrl_type                        csr_ctrl;

   logic [FLAGS_WIDTH-1:0]              flags_ff, flags_in;
   logic [COUNT_WIDTH-1:0]              run_ff, run_in;
   logic [COUNT_WIDTH-1:0]              total_ff, total_in;
   logic [COUNT_WIDTH-1:0]              split_ff, split_in;
   logic [LAP_COUNT-1:0][COUNT_WIDTH-1:0] laps_ff, laps_in;

   logic [FLAGS_WIDTH-1:0]              flags_nx;
   logic [COUNT_WIDTH-1:0]              run_nx, total_nx, split_nx;
   logic [LAP_COUNT-1:0][COUNT_WIDTH-1:0] laps_nx;
   logic                                refused_nx;
   logic [TIME_WIDTH-1:0]               lap_one_nx;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [FLAGS_WIDTH-1:0]              rsp_flags_ff;
   logic [TIME_WIDTH-1:0]               rsp_run_ff, rsp_total_ff, rsp_split_ff;
   logic [TIME_WIDTH-1:0]               rsp_lap0_ff, rsp_lap1_ff;
   logic                                rsp_refused_ff;

   logic                                accept;

   // register block
   swl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr_ctrl    (csr_ctrl)
   );

   // command update logic
   swl_next #(
      .LAP_COUNT   (LAP_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_next (
      .opcode     (req_chan.opcode),
      .lap_select (req_chan.lap_select),
      .delta      (req_chan.delta),
      .flags_cur  (flags_ff),
      .run_cur    (run_ff),
      .total_cur  (total_ff),
      .split_cur  (split_ff),
      .laps_cur   (laps_ff),
      .flags_nx   (flags_nx),
      .run_nx     (run_nx),
      .total_nx   (total_nx),
      .split_nx   (split_nx),
      .laps_nx    (laps_nx),
      .refused    (refused_nx)
   );

   // handshake: take a request whenever the result slot frees up
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // state next values; register writes must only arrive while idle, a user rule the block does not enforce
   always_comb begin
      flags_in = flags_ff;
      run_in   = run_ff;
      total_in = total_ff;
      split_in = split_ff;
      laps_in  = laps_ff;
      priority if (accept) begin
         flags_in = flags_nx;
         run_in   = run_nx;
         total_in = total_nx;
         split_in = split_nx;
         laps_in  = laps_nx;
      end else if (csr_ctrl.lock_wr) begin
         flags_in = csr_ctrl.lock_value ? (flags_ff | FLAG_LOCK) : (flags_ff & ~FLAG_LOCK);
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         run_ff   <= '0;
         total_ff <= '0;
         split_ff <= '0;
         laps_ff  <= '0;
      end else begin
         flags_ff <= flags_in;
         run_ff   <= run_in;
         total_ff <= total_in;
         split_ff <= split_in;
         laps_ff  <= laps_in;
      end
   end

   // second lap output exists only with two or more laps
   if (LAP_COUNT >= 2) begin : g_lap_one
      assign lap_one_nx = fit_time(laps_nx[1]);
   end else begin : g_no_lap_one
      assign lap_one_nx = '0;
   end

   // result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_flags_ff   <= flags_nx;
         rsp_run_ff     <= fit_time(run_nx);
         rsp_total_ff   <= fit_time(total_nx);
         rsp_split_ff   <= fit_time(split_nx);
         rsp_lap0_ff    <= fit_time(laps_nx[0]);
         rsp_lap1_ff    <= lap_one_nx;
         rsp_refused_ff <= refused_nx;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status_flags  = rsp_flags_ff;
   assign rsp_chan.run_time      = rsp_run_ff;
   assign rsp_chan.total_time    = rsp_total_ff;
   assign rsp_chan.split_time    = rsp_split_ff;
   assign rsp_chan.lap_zero_time = rsp_lap0_ff;
   assign rsp_chan.lap_one_time  = rsp_lap1_ff;
   assign rsp_chan.start_refused = rsp_refused_ff;

   // stop always leaves running, split armed and lock cleared
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.opcode == OP_STOP |=>
         (rsp_flags_ff & (FLAG_RUNNING | FLAG_SPLIT | FLAG_LOCK)) == '0)
      else $error("stop left running, split or lock set");

   // a locked start is refused and leaves the run counter alone
   a_locked_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.opcode == OP_START && flags_ff[FLAGS_WIDTH-1] |=>
         rsp_refused_ff && run_ff == $past(run_ff))
      else $error("locked start was not refused");

   // a result appears only after an accepted request
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result valid without a request");

   // an idle register write reloads the lock flag
   a_lock_reload: assert property (@(posedge clock) disable iff (reset)
      csr_ctrl.lock_wr && !accept |=>
         flags_ff[FLAGS_WIDTH-1] == $past(csr_ctrl.lock_value))
      else $error("lock flag not loaded by register write");

endmodule

>>> tb/session_stopwatch_with_laps_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_stopwatch_with_laps_tb
// Self-checking bench for the session stopwatch. Commands go in over the
// request channel with random gaps. A scoreboard class predicts the flag byte
// and every counter for each accepted command and checks each result in order.
// The lock register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module session_stopwatch_with_laps_tb;
   import swl_pkg::*;

   localparam int LAPS             = 2;
   localparam int MAX_IDLE         = 18;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES    = 4;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_ITEMS      = 185;
   localparam int RUN_LIMIT_NS     = 2_000_000;

   // one result as seen on the result channel
   typedef struct {
      logic [FLAGS_WIDTH-1:0] flags;
      logic [TIME_WIDTH-1:0]  run_t;
      logic [TIME_WIDTH-1:0]  total_t;
      logic [TIME_WIDTH-1:0]  split_t;
      logic [TIME_WIDTH-1:0]  lap0_t;
      logic [TIME_WIDTH-1:0]  lap1_t;
      logic                   refused;
   } stopwatch_result_type;

   // stopwatch state mirror and in-order store of expected results
   class stopwatch_scoreboard_type;
      logic [FLAGS_WIDTH-1:0] flag_byte;
      logic [TIME_WIDTH-1:0]  run_cnt;
      logic [TIME_WIDTH-1:0]  total_cnt;
      logic [TIME_WIDTH-1:0]  split_cnt;
      logic [TIME_WIDTH-1:0]  lap_cnt [LAPS];
      stopwatch_result_type   expected_results [$];
      int unsigned            commands;
      int unsigned            refused_starts;
      int unsigned            results_checked;
      int unsigned            mismatches;

      function new();
         flag_byte = '0;
         run_cnt = '0;
         total_cnt = '0;
         split_cnt = '0;
         foreach (lap_cnt[k]) lap_cnt[k] = '0;
         commands = 0;
         refused_starts = 0;
         results_checked = 0;
         mismatches = 0;
      endfunction

      // register write also loads the lock flag at once
      function void load_lock(logic value);
         if (value) flag_byte = flag_byte | FLAG_LOCK;
         else flag_byte = flag_byte & ~FLAG_LOCK;
      endfunction

      function void advance(logic [TIME_WIDTH-1:0] d, bit with_split);
         run_cnt = run_cnt + d;
         total_cnt = total_cnt + d;
         if (with_split && (flag_byte & FLAG_SPLIT) != 0) split_cnt = split_cnt + d;
         for (int k = 0; k < LAPS; k++)
            if ((flag_byte & (FLAG_LAP0 << k)) != 0) lap_cnt[k] = lap_cnt[k] + d;
      endfunction

      // apply one accepted command and queue the result it must produce
      function void note_command(logic [OPCODE_WIDTH-1:0] op, logic sel,
                                 logic [DELTA_WIDTH-1:0] d);
         stopwatch_result_type res;
         logic refused;
         refused = 1'b0;
         case (op)
            OP_START: begin
               if ((flag_byte & FLAG_LOCK) != 0) begin
                  refused = 1'b1;
                  refused_starts++;
               end else begin
                  run_cnt = '0;
                  flag_byte = (flag_byte & ~FLAG_STOPPED) | FLAG_RUNNING;
               end
            end
            OP_TICK: advance(d, 1'b1);
            OP_STOP: begin
               // split holds still on stop
               advance(d, 1'b0);
               flag_byte = flag_byte | FLAG_STOPPED;
               flag_byte = flag_byte & ~(FLAG_RUNNING | FLAG_SPLIT | FLAG_LOCK);
            end
            OP_ARM_SPLIT: begin
               split_cnt = '0;
               flag_byte = flag_byte | FLAG_SPLIT;
            end
            OP_DISARM_SPLIT: flag_byte = flag_byte & ~FLAG_SPLIT;
            OP_ARM_LAP: begin
               lap_cnt[sel] = '0;
               flag_byte = flag_byte | (FLAG_LAP0 << sel);
            end
            OP_DISARM_LAP: flag_byte = flag_byte & ~(FLAG_LAP0 << sel);
            default: ;
         endcase
         res.flags = flag_byte;
         res.run_t = run_cnt;
         res.total_t = total_cnt;
         res.split_t = split_cnt;
         res.lap0_t = lap_cnt[0];
         res.lap1_t = lap_cnt[1];
         res.refused = refused;
         expected_results.push_back(res);
         commands++;
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_result(stopwatch_result_type got);
         stopwatch_result_type exp_r;
         if (expected_results.size() == 0) begin
            $error("result with no command outstanding: flags %h run %h",
                   got.flags, got.run_t);
            mismatches++;
            return;
         end
         exp_r = expected_results.pop_front();
         compare_field("status_flags", 32'(exp_r.flags), 32'(got.flags));
         compare_field("run_time", exp_r.run_t, got.run_t);
         compare_field("total_time", exp_r.total_t, got.total_t);
         compare_field("split_time", exp_r.split_t, got.split_t);
         compare_field("lap_zero_time", exp_r.lap0_t, got.lap0_t);
         compare_field("lap_one_time", exp_r.lap1_t, got.lap1_t);
         compare_field("start_refused", 32'(exp_r.refused), 32'(got.refused));
         results_checked++;
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      function void report_leftovers();
         if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   swl_req_if req_bus ();
   swl_rsp_if rsp_bus ();

   stopwatch_scoreboard_type tracker = new();

   // idle modes per phase and long hold requests, written by the stimulus only
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int long_holds_asked = 0;
   int lock_settings = 0;

   session_stopwatch_with_laps u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $error("run did not finish in time, %0d results outstanding", tracker.outstanding());
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check at the rising edge, drive ready at the falling edge
   initial begin : rsp_side
      stopwatch_result_type got;
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.flags = rsp_bus.status_flags;
            got.run_t = rsp_bus.run_time;
            got.total_t = rsp_bus.total_time;
            got.split_t = rsp_bus.split_time;
            got.lap0_t = rsp_bus.lap_zero_time;
            got.lap1_t = rsp_bus.lap_one_time;
            got.refused = rsp_bus.start_refused;
            tracker.check_result(got);
            stall_left = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         @(negedge clock);
         if (holds_done != long_holds_asked) begin
            holds_done = long_holds_asked;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offer one command and wait until it is taken
   task automatic send_command(logic [OPCODE_WIDTH-1:0] op, logic sel,
                               logic [DELTA_WIDTH-1:0] d);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.lap_select <= sel;
      req_bus.delta <= d;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_command(op, sel, d);
   endtask

   // drop valid, then wait until every expected result is in
   task automatic wait_for_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'(idx) << CSR_INDEX_LSB;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      if (idx == REG_LOCK_AT_RESET) tracker.load_lock(value[0]);
      lock_settings++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // a mix of the extremes, small values of either sign and full-range values
   function automatic logic [DELTA_WIDTH-1:0] pick_delta();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return '0;
         4, 5: return 32'($urandom_range(1, 1000));
         6: return -32'($urandom_range(1, 1000));
         default: return $urandom;
      endcase
   endfunction

   // one start..stop session with random content; a few end without a stop
   task automatic run_session();
      int n;
      send_command(OP_START, 1'($urandom), pick_delta());
      if ($urandom_range(0, 1) == 1) send_command(OP_ARM_SPLIT, 1'($urandom), pick_delta());
      for (int k = 0; k < LAPS; k++)
         if ($urandom_range(0, 2) != 0) send_command(OP_ARM_LAP, k[0], pick_delta());
      n = $urandom_range(1, 8);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: send_command(OP_ARM_SPLIT, 1'($urandom), pick_delta());
            1: send_command(OP_DISARM_SPLIT, 1'($urandom), pick_delta());
            2: send_command(OP_ARM_LAP, 1'($urandom), pick_delta());
            3: send_command(OP_DISARM_LAP, 1'($urandom), pick_delta());
            default: send_command(OP_TICK, 1'($urandom), pick_delta());
         endcase
      end
      if ($urandom_range(0, 7) != 0) send_command(OP_STOP, 1'($urandom), pick_delta());
   endtask

   // stimulus
   initial begin : stimulus
      int phase_end;
      bit hold_asked;
      bit drain_done;
      hold_asked = 1'b0;
      drain_done = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= '0;
      req_bus.lap_select <= 1'b0;
      req_bus.delta <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, wrap, every opcode, unlocked
      csr_write(REG_LOCK_AT_RESET, 32'd0);
      send_command(OP_TICK, 1'b0, 32'd7);
      send_command(OP_START, 1'b1, 32'hffff_ffff);
      send_command(OP_TICK, 1'b0, 32'h7fff_ffff);
      send_command(OP_TICK, 1'b1, 32'd1);
      send_command(OP_ARM_SPLIT, 1'b1, 32'h8000_0000);
      send_command(OP_TICK, 1'b0, 32'h8000_0000);
      send_command(OP_ARM_LAP, 1'b0, 32'd0);
      send_command(OP_ARM_LAP, 1'b1, 32'd0);
      send_command(OP_TICK, 1'b1, 32'hffff_ffff);
      send_command(OP_TICK, 1'b0, 32'd0);
      send_command(OP_DISARM_LAP, 1'b1, 32'd0);
      send_command(OP_TICK, 1'b0, 32'd12345);
      send_command(OP_DISARM_SPLIT, 1'b0, 32'd0);
      send_command(OP_TICK, 1'b1, 32'd100);
      send_command(OP_STOP, 1'b0, 32'h7fff_ffff);
      send_command(6'd7, 1'b1, 32'hffff_ffff);
      send_command(6'd63, 1'b0, 32'h5555_aaaa);
      send_command(OP_DISARM_LAP, 1'b0, 32'd0);
      send_command(OP_START, 1'b0, 32'd0);

      // directed: lock blocks start until a stop clears it
      wait_for_idle();
      csr_write(REG_LOCK_AT_RESET, 32'd1);
      send_command(OP_START, 1'b0, 32'd0);
      send_command(OP_TICK, 1'b1, 32'd5);
      send_command(OP_STOP, 1'b0, -32'd3);
      send_command(OP_START, 1'b1, 32'd0);
      wait_for_idle();
      csr_write(REG_LOCK_AT_RESET, 32'hffff_ffff);
      send_command(OP_START, 1'b0, 32'd9);

      // random phases, each under its own lock setting and idle mode
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_idle();
         if (phase == 0) csr_write(REG_LOCK_AT_RESET, 32'd0);
         else if (phase == 1) csr_write(REG_LOCK_AT_RESET, 32'd1);
         else csr_write(REG_LOCK_AT_RESET, {31'($urandom), 1'($urandom)});
         if (phase == 2) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on = $urandom_range(0, 3) != 0;
         end
         phase_end = tracker.commands + PHASE_ITEMS;
         while (tracker.commands < phase_end) begin
            // receiver holds off for long while commands keep coming
            if (phase == 3 && !hold_asked && tracker.commands + 150 >= phase_end) begin
               long_holds_asked++;
               hold_asked = 1'b1;
            end
            // sender pauses until the block has drained
            if (phase == 5 && !drain_done && tracker.commands + 100 >= phase_end) begin
               wait_for_idle();
               drain_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) run_session();
            else send_command(6'($urandom_range(0, 63)), 1'($urandom), pick_delta());
         end
      end

      // end of run
      wait_for_idle();
      repeat (8) @(posedge clock);
      tracker.report_leftovers();
      $display("Ran %0d commands over %0d lock register writes; %0d starts refused by lock.",
               tracker.commands, lock_settings, tracker.refused_starts);
      $display("Checked %0d results, %0d mismatches.", tracker.results_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/swl_pkg.sv
sv/swl_req_if.sv
sv/swl_rsp_if.sv
sv/swl_csr.sv
sv/swl_next.sv
sv/session_stopwatch_with_laps.sv
tb/session_stopwatch_with_laps_tb.sv
